>>> design/obd_rm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_rm_pkg
// Types and constants shared by the OBD reply matcher front end, command
// queue and back end.
// ----------------------------------------------------------------------------
package obd_rm_pkg;

  // input op codes (s_tuser)
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_FRAME   = 3'd1;
  localparam logic [2:0] OP_TICK    = 3'd2;
  localparam logic [2:0] OP_TX_FAIL = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_ID_FIRST    = 2'd0;
  localparam logic [1:0] REG_ID_LAST     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;
  localparam logic [1:0] REG_MODE_OFFSET = 2'd3;

  // register reset values
  localparam logic [10:0] RST_ID_FIRST    = 11'd2024;
  localparam logic [10:0] RST_ID_LAST     = 11'd2031;
  localparam logic [15:0] RST_TIMEOUT     = 16'd100;
  localparam logic [7:0]  RST_MODE_OFFSET = 8'd64;

  // ISO-TP PCI frame type nibbles
  localparam logic [3:0] PCI_SINGLE = 4'h0;
  localparam logic [3:0] PCI_FIRST  = 4'h1;
  localparam logic [2:0] PCI_LEN_MIN = 3'd2;

  // payload bytes carried in the result word
  localparam int PAYLOAD_MAX_BYTES = 5;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_FRAME   = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_TX_FAIL = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_kind_t;

  typedef enum logic [1:0] {
    FR_SINGLE = 2'd0,  // well-formed single frame
    FR_MULTI  = 2'd1,  // ISO-TP first frame
    FR_OTHER  = 2'd2,  // consecutive / flow control, ignored
    FR_BADPCI = 2'd3   // single frame with an illegal length
  } frame_class_t;

  typedef enum logic [2:0] {
    OUT_OK       = 3'd0,
    OUT_MULTI    = 3'd1,
    OUT_TOO_LONG = 3'd2,
    OUT_TIMEOUT  = 3'd3,
    OUT_TX_FAIL  = 3'd4
  } outcome_t;

  // classified command, front end to back end
  typedef struct packed {
    cmd_kind_t    kind;
    logic [10:0]  id;
    logic [15:0]  mask_bit;   // responder bit, zero when offset >= 16
    frame_class_t fclass;
    logic [7:0]   mode;       // expected mode (start) or echoed mode (frame)
    logic [7:0]   pid;        // requested pid (start) or echoed pid (frame)
    logic [2:0]   len;
    logic         too_long;
    logic [8*PAYLOAD_MAX_BYTES-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [31:0] multiframe_total;
    logic [31:0] malformed_total;
    logic [31:0] timeouts_total;
    logic [31:0] replies_total;
    logic [31:0] requests_total;
    logic [15:0] responders_seen;
    logic [15:0] elapsed_ticks;
    logic [8*PAYLOAD_MAX_BYTES-1:0] payload;
    logic [2:0]  payload_length;
    logic [10:0] responder_id;
    outcome_t    outcome;
  } result_t;

endpackage

>>> design/obd_rm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_rm_front
// Accepts input words, drops those that can never have an effect and
// classifies the rest into commands for the queue.
// ----------------------------------------------------------------------------
module obd_rm_front
  import obd_rm_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 5
) (
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // req_mode, req_pid, frame_id, frame_extended, frame_bytes
  input  logic [2:0]  s_tuser,   // op
  input  logic [10:0] id_first,
  input  logic [10:0] id_last,
  input  logic [7:0]  mode_offset,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [7:0]  req_mode;
  logic [7:0]  req_pid;
  logic [10:0] frame_id;
  logic        frame_ext;
  logic [63:0] frame_bytes;
  logic [7:0]  pci;
  logic [10:0] offset;
  logic        in_range;
  logic        keep;
  logic [2:0]  len;

  assign req_mode    = s_tdata[7:0];
  assign req_pid     = s_tdata[15:8];
  assign frame_id    = s_tdata[26:16];
  assign frame_ext   = s_tdata[27];
  assign frame_bytes = s_tdata[91:28];
  assign pci         = frame_bytes[7:0];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready && keep;

  // id window and responder offset
  assign in_range = (frame_id >= id_first) && (frame_id <= id_last);
  assign offset   = frame_id - id_first;
  assign len      = pci[2:0] - PCI_LEN_MIN;

  // classify
  always_comb begin
    keep          = 1'b1;
    q_cmd         = '0;
    q_cmd.kind    = CMD_START;
    q_cmd.id      = frame_id;
    q_cmd.mask_bit = (offset[10:4] == '0) ? (16'd1 << offset[3:0]) : 16'd0;
    q_cmd.len     = len;
    q_cmd.too_long = (len > 3'(PAYLOAD_BYTES));
    for (int i = 0; i < PAYLOAD_MAX_BYTES; i++) begin
      if (3'(i) < len) begin
        q_cmd.payload[8*i +: 8] = frame_bytes[24 + 8*i +: 8];
      end
    end
    if (pci[7:4] == PCI_FIRST) begin
      q_cmd.fclass = FR_MULTI;
    end else if (pci[7:4] != PCI_SINGLE) begin
      q_cmd.fclass = FR_OTHER;
    end else if (pci[3:0] < 4'(PCI_LEN_MIN) || pci[3:0] > 4'd7) begin
      q_cmd.fclass = FR_BADPCI;
    end else begin
      q_cmd.fclass = FR_SINGLE;
    end
    unique case (s_tuser)
      OP_START: begin
        q_cmd.kind = CMD_START;
        q_cmd.mode = req_mode + mode_offset;
        q_cmd.pid  = req_pid;
      end
      OP_FRAME: begin
        q_cmd.kind = CMD_FRAME;
        q_cmd.mode = frame_bytes[15:8];
        q_cmd.pid  = frame_bytes[23:16];
        keep       = !frame_ext && in_range;
      end
      OP_TICK:    q_cmd.kind = CMD_TICK;
      OP_TX_FAIL: q_cmd.kind = CMD_TX_FAIL;
      OP_CLEAR:   q_cmd.kind = CMD_CLEAR;
      default:    keep = 1'b0;
    endcase
  end

endmodule

>>> design/obd_rm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_rm_queue
// Short command FIFO between front end and back end.
// ----------------------------------------------------------------------------
module obd_rm_queue
  import obd_rm_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |-> !push)
    else $error("queue pushed while full");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count out of step");

endmodule

>>> design/obd_rm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_rm_back
// Executes queued commands against the wait state and the statistics and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
module obd_rm_back
  import obd_rm_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] timeout_ticks,
  input  cmd_t        cmd,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output result_t     result
);

  logic        waiting, waiting_next;
  logic [7:0]  exp_mode, exp_mode_next;
  logic [7:0]  exp_pid, exp_pid_next;
  logic [15:0] elapsed, elapsed_next;
  logic [15:0] resp_mask, resp_mask_next;
  logic [31:0] req_cnt, req_cnt_next;
  logic [31:0] reply_cnt, reply_cnt_next;
  logic [31:0] tmo_cnt, tmo_cnt_next;
  logic [31:0] bad_cnt, bad_cnt_next;
  logic [31:0] multi_cnt, multi_cnt_next;
  logic        emit;
  result_t     res;
  logic        echo_match;

  assign q_pop      = !q_empty && (!m_tvalid || m_tready);
  assign echo_match = (cmd.mode == exp_mode) && (cmd.pid == exp_pid);

  // command execution
  always_comb begin
    waiting_next   = waiting;
    exp_mode_next  = exp_mode;
    exp_pid_next   = exp_pid;
    elapsed_next   = elapsed;
    resp_mask_next = resp_mask;
    req_cnt_next   = req_cnt;
    reply_cnt_next = reply_cnt;
    tmo_cnt_next   = tmo_cnt;
    bad_cnt_next   = bad_cnt;
    multi_cnt_next = multi_cnt;
    emit           = 1'b0;
    res            = '0;
    res.outcome    = OUT_OK;
    if (q_pop) begin
      unique case (cmd.kind)
        CMD_START: begin
          req_cnt_next  = req_cnt + 1'b1;
          exp_mode_next = cmd.mode;
          exp_pid_next  = cmd.pid;
          elapsed_next  = '0;
          waiting_next  = 1'b1;
        end
        CMD_FRAME: begin
          if (waiting) begin
            resp_mask_next = resp_mask | cmd.mask_bit;
            unique case (cmd.fclass)
              FR_MULTI: begin
                multi_cnt_next   = multi_cnt + 1'b1;
                emit             = 1'b1;
                res.outcome      = OUT_MULTI;
                res.responder_id = cmd.id;
              end
              FR_BADPCI: bad_cnt_next = bad_cnt + 1'b1;
              FR_SINGLE: begin
                if (echo_match) begin
                  emit = 1'b1;
                  if (cmd.too_long) begin
                    bad_cnt_next = bad_cnt + 1'b1;
                    res.outcome  = OUT_TOO_LONG;
                  end else begin
                    reply_cnt_next     = reply_cnt + 1'b1;
                    res.outcome        = OUT_OK;
                    res.responder_id   = cmd.id;
                    res.payload_length = cmd.len;
                    res.payload        = cmd.payload;
                    res.elapsed_ticks  = elapsed;
                  end
                end
              end
              FR_OTHER: ;
            endcase
          end
        end
        CMD_TICK: begin
          if (waiting) begin
            elapsed_next = elapsed + 1'b1;
            if (elapsed_next >= timeout_ticks) begin
              tmo_cnt_next = tmo_cnt + 1'b1;
              emit         = 1'b1;
              res.outcome  = OUT_TIMEOUT;
            end
          end
        end
        CMD_TX_FAIL: begin
          if (waiting) begin
            tmo_cnt_next = tmo_cnt + 1'b1;
            emit         = 1'b1;
            res.outcome  = OUT_TX_FAIL;
          end
        end
        CMD_CLEAR: begin
          resp_mask_next = '0;
          req_cnt_next   = '0;
          reply_cnt_next = '0;
          tmo_cnt_next   = '0;
          bad_cnt_next   = '0;
          multi_cnt_next = '0;
        end
        default: ;
      endcase
      if (emit) begin
        waiting_next = 1'b0;
      end
    end
    // statistics after this command's update
    res.responders_seen  = resp_mask_next;
    res.requests_total   = req_cnt_next;
    res.replies_total    = reply_cnt_next;
    res.timeouts_total   = tmo_cnt_next;
    res.malformed_total  = bad_cnt_next;
    res.multiframe_total = multi_cnt_next;
  end

  // wait state and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting   <= 1'b0;
      exp_mode  <= '0;
      exp_pid   <= '0;
      elapsed   <= '0;
      resp_mask <= '0;
      req_cnt   <= '0;
      reply_cnt <= '0;
      tmo_cnt   <= '0;
      bad_cnt   <= '0;
      multi_cnt <= '0;
    end else begin
      waiting   <= waiting_next;
      exp_mode  <= exp_mode_next;
      exp_pid   <= exp_pid_next;
      elapsed   <= elapsed_next;
      resp_mask <= resp_mask_next;
      req_cnt   <= req_cnt_next;
      reply_cnt <= reply_cnt_next;
      tmo_cnt   <= tmo_cnt_next;
      bad_cnt   <= bad_cnt_next;
      multi_cnt <= multi_cnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res;
    end
  end

  a_emit_ends_wait: assert property (@(posedge clk) disable iff (rst)
    emit |=> !waiting)
    else $error("wait still open after a result");
  a_emit_needs_wait: assert property (@(posedge clk) disable iff (rst)
    emit |-> waiting)
    else $error("result produced with no request waiting");
  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.outcome == OUT_OK) |-> (result.payload_length <= 3'(PAYLOAD_BYTES)))
    else $error("reply length beyond payload buffer");

endmodule

>>> design/obd_reply_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_reply_matcher_core
// Matches single-frame OBD-II replies on CAN against the outstanding request.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (s_*) carry an op in s_tuser: start request, received frame,
//   millisecond tick, transmit failure or clear statistics. A start arms the
//   matcher; frames, ticks and failures while no request waits are dropped.
//   Each ended wait (reply, multiframe, overlong payload, timeout, transmit
//   failure) yields one result word on m_* with the statistics after update.
//   Registers on the APB port set the responder id window, the timeout and
//   the reply mode offset; write them only while the block is idle.
// Timing:
//   One word per cycle sustained while the queue is not full. A word accepted
//   enters the command queue, and the back end executes it once it heads the
//   queue and the output register is empty or being read; its result is
//   registered onto m_*. The front end classifies in the accept cycle; the
//   back end executes one command per cycle out of the QUEUE_DEPTH queue while not stalled.
// Reset clears the wait, the statistics and the queue and loads register
// defaults. When the receiver stalls, the result register holds, the back end
// stops popping and s_tready falls once the queue is full.
// ----------------------------------------------------------------------------
module obd_reply_matcher_core
  import obd_rm_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 5,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,  // req_mode[7:0], req_pid[15:8], frame_id[26:16],
                                 // frame_extended[27], frame_bytes[91:28]
  input  logic [2:0]   s_tuser,  // op
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata,  // outcome[2:0], responder_id[13:3],
                                 // payload_length[16:14], payload[56:17],
                                 // elapsed_ticks[72:57], responders_seen[88:73],
                                 // requests_total[120:89], replies_total[152:121],
                                 // timeouts_total[184:153], malformed_total[216:185],
                                 // multiframe_total[248:217]
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [10:0] id_first;
  logic [10:0] id_last;
  logic [15:0] timeout_ticks;
  logic [7:0]  mode_offset;
  logic        cfg_wr;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  logic        q_full;
  cmd_t        q_in;
  cmd_t        q_head;
  result_t     result;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_first      <= RST_ID_FIRST;
      id_last       <= RST_ID_LAST;
      timeout_ticks <= RST_TIMEOUT;
      mode_offset   <= RST_MODE_OFFSET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ID_FIRST:    id_first      <= pwdata[10:0];
        REG_ID_LAST:     id_last       <= pwdata[10:0];
        REG_TIMEOUT:     timeout_ticks <= pwdata[15:0];
        REG_MODE_OFFSET: mode_offset   <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ID_FIRST:    prdata = {21'd0, id_first};
      REG_ID_LAST:     prdata = {21'd0, id_last};
      REG_TIMEOUT:     prdata = {16'd0, timeout_ticks};
      REG_MODE_OFFSET: prdata = {24'd0, mode_offset};
    endcase
  end

  obd_rm_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .id_first    (id_first),
    .id_last     (id_last),
    .mode_offset (mode_offset),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_in)
  );

  obd_rm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  obd_rm_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .timeout_ticks (timeout_ticks),
    .cmd           (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .result        (result)
  );

  // result word, first field in the low bits
  assign m_tdata = {7'd0,
                    result.multiframe_total,
                    result.malformed_total,
                    result.timeouts_total,
                    result.replies_total,
                    result.requests_total,
                    result.responders_seen,
                    result.elapsed_ticks,
                    result.payload,
                    result.payload_length,
                    result.responder_id,
                    result.outcome};

endmodule
